// File: sv/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) \
        else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr)
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`endif

`endif

// File: sv/qrs_pkg.sv
package qrs_pkg;

    localparam int COEF_W        = 16;
    localparam int COEF_FRAC     = 8;
    localparam int ROOT_FRAC_DEF = 16;
    localparam int OUT_BITS      = 40;

    localparam logic [1:0] CNT_NONE   = 2'd0;
    localparam logic [1:0] CNT_DOUBLE = 2'd1;
    localparam logic [1:0] CNT_TWO    = 2'd2;
    localparam logic [1:0] CNT_AZERO  = 2'd3;

    typedef struct packed {
        logic signed [COEF_W-1:0] coef_a;
        logic signed [COEF_W-1:0] coef_b;
        logic signed [COEF_W-1:0] coef_c;
    } qrs_in_t;

    typedef struct packed {
        logic [1:0]                 root_count;
        logic signed [OUT_BITS-1:0] root_first;
        logic signed [OUT_BITS-1:0] root_second;
    } qrs_out_t;

    // Side data riding along the square root chain
    typedef struct packed {
        logic [1:0]               count;
        logic signed [COEF_W-1:0] a;
        logic signed [COEF_W-1:0] b;
    } qrs_sq_side_t;

    // Side data riding along the divider chain
    typedef struct packed {
        logic [1:0] count;
        logic       neg1;
        logic       neg2;
    } qrs_div_side_t;

endpackage

// File: sv/qrs_sqrt_cell.sv
module qrs_sqrt_cell #(
    parameter int RW = 26
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  logic [RW+1:0]   rem_in,
    input  logic [RW-1:0]   root_in,
    input  logic [2*RW-1:0] rad_in,
    output logic            out_valid,
    output logic [RW+1:0]   rem_out,
    output logic [RW-1:0]   root_out,
    output logic [2*RW-1:0] rad_out
);
    localparam int RADW = 2 * RW;

    logic            valid_reg;
    logic [RW+1:0]   rem_reg, rem_next;
    logic [RW-1:0]   root_reg, root_next;
    logic [RADW-1:0] rad_reg, rad_next;
    logic [RW+1:0]   rem_sh, trial;
    logic            ge;

    // One restoring step: bring down two radicand bits, try root*4+1
    always_comb
    begin
        rem_sh    = {rem_in[RW-1:0], rad_in[RADW-1 -: 2]};
        trial     = {root_in, 2'b01};
        ge        = (rem_sh >= trial);
        rem_next  = ge ? (rem_sh - trial) : rem_sh;
        root_next = {root_in[RW-2:0], ge};
        rad_next  = {rad_in[RADW-3:0], 2'b00};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        root_reg <= root_next;
        rad_reg  <= rad_next;
    end

    assign out_valid = valid_reg;
    assign rem_out   = rem_reg;
    assign root_out  = root_reg;
    assign rad_out   = rad_reg;
endmodule

// File: sv/qrs_div_cell.sv
module qrs_div_cell #(
    parameter int QW   = 36,
    parameter int DENW = 17
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  logic [DENW-1:0] den_in,
    input  logic [DENW-1:0] rem1_in,
    input  logic [QW-1:0]   num1_in,
    input  logic [DENW-1:0] rem2_in,
    input  logic [QW-1:0]   num2_in,
    output logic            out_valid,
    output logic [DENW-1:0] den_out,
    output logic [DENW-1:0] rem1_out,
    output logic [QW-1:0]   num1_out,
    output logic [DENW-1:0] rem2_out,
    output logic [QW-1:0]   num2_out
);
    logic            valid_reg;
    logic [DENW-1:0] den_reg;
    logic [DENW-1:0] rem1_reg, rem1_next, rem2_reg, rem2_next;
    logic [QW-1:0]   num1_reg, num1_next, num2_reg, num2_next;
    logic [DENW:0]   sh1, sh2, den_ext;
    logic            ge1, ge2;

    // One restoring step per lane; quotient bits shift in from the right
    always_comb
    begin
        den_ext   = {1'b0, den_in};
        sh1       = {rem1_in, num1_in[QW-1]};
        sh2       = {rem2_in, num2_in[QW-1]};
        ge1       = (sh1 >= den_ext);
        ge2       = (sh2 >= den_ext);
        rem1_next = ge1 ? DENW'(sh1 - den_ext) : sh1[DENW-1:0];
        rem2_next = ge2 ? DENW'(sh2 - den_ext) : sh2[DENW-1:0];
        num1_next = {num1_in[QW-2:0], ge1};
        num2_next = {num2_in[QW-2:0], ge2};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        den_reg  <= den_in;
        rem1_reg <= rem1_next;
        rem2_reg <= rem2_next;
        num1_reg <= num1_next;
        num2_reg <= num2_next;
    end

    assign out_valid = valid_reg;
    assign den_out   = den_reg;
    assign rem1_out  = rem1_reg;
    assign num1_out  = num1_reg;
    assign rem2_out  = rem2_reg;
    assign num2_out  = num2_reg;
endmodule

// File: sv/quadratic_root_solver.sv
// Pipeline: capture, product and discriminant stages, one square root cell per root bit, the
// numerator stage, one divider cell per quotient bit, then the output register.
// Throughput: one transaction per clock; busy is always low and the receiver cannot stall.
// Reset: rst_n clears all valid flags at once; payload registers are not reset.
`include "assert_macros.svh"

module quadratic_root_solver #(
    parameter int ROOT_FRAC_BITS = qrs_pkg::ROOT_FRAC_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  qrs_pkg::qrs_in_t coef,
    output logic             done,
    output qrs_pkg::qrs_out_t result
);
    import qrs_pkg::*;

    // Radicand shift: root gets ROOT_FRAC_BITS fraction bits from a D with 2*COEF_FRAC
    localparam int SH    = 2 * ROOT_FRAC_BITS - 2 * COEF_FRAC;
    localparam int DW    = 2 * COEF_W + 3;
    localparam int RW    = (DW + SH + 1) / 2;
    localparam int RADW  = 2 * RW;
    localparam int BSW   = COEF_W + ROOT_FRAC_BITS - COEF_FRAC;
    localparam int NUMW  = ((BSW > RW) ? BSW : RW) + 2;
    localparam int QW    = NUMW + COEF_FRAC;
    localparam int DENW  = COEF_W + 1;
    localparam int SATW  = ((QW > OUT_BITS) ? QW : OUT_BITS) + 1;
    localparam int LAT   = 5 + RW + QW;

    // ---------------- stage 0: capture the transaction ----------------
    logic                     s0_valid_reg;
    logic signed [COEF_W-1:0] s0_a_reg, s0_b_reg, s0_c_reg;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
        end
        else
        begin
            s0_valid_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        s0_a_reg <= coef.coef_a;
        s0_b_reg <= coef.coef_b;
        s0_c_reg <= coef.coef_c;
    end

    // ---------------- stage 1: the two products ----------------
    logic                       s1_valid_reg;
    logic signed [2*COEF_W-1:0] s1_bb_reg, s1_ac_reg;
    logic signed [COEF_W-1:0]   s1_a_reg, s1_b_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s0_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_bb_reg <= s0_b_reg * s0_b_reg;
        s1_ac_reg <= s0_a_reg * s0_c_reg;
        s1_a_reg  <= s0_a_reg;
        s1_b_reg  <= s0_b_reg;
    end

    // ---------------- stage 2: discriminant and root class ----------------
    logic signed [DW-1:0] disc;
    logic [1:0]           count_next;

    always_comb
    begin
        disc = DW'(s1_bb_reg) - (DW'(s1_ac_reg) <<< 2);
        if (s1_a_reg == '0)
        begin
            count_next = CNT_AZERO;
        end
        else if (disc[DW-1])
        begin
            count_next = CNT_NONE;
        end
        else if (disc == '0)
        begin
            count_next = CNT_DOUBLE;
        end
        else
        begin
            count_next = CNT_TWO;
        end
    end

    logic            sq_valid [0:RW];
    logic [RW+1:0]   sq_rem   [0:RW];
    logic [RW-1:0]   sq_root  [0:RW];
    logic [RADW-1:0] sq_rad   [0:RW];
    qrs_sq_side_t    sq_side_reg [0:RW];

    logic            s2_valid_reg;
    logic [RADW-1:0] s2_rad_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        // a negative D feeds junk to the root; its roots are dropped at the end
        s2_rad_reg         <= RADW'($unsigned(disc)) << SH;
        sq_side_reg[0].count <= count_next;
        sq_side_reg[0].a     <= s1_a_reg;
        sq_side_reg[0].b     <= s1_b_reg;
    end

    assign sq_valid[0] = s2_valid_reg;
    assign sq_rem[0]   = '0;
    assign sq_root[0]  = '0;
    assign sq_rad[0]   = s2_rad_reg;

    // ---------------- square root chain: one cell per root bit ----------------
    for (genvar i = 0; i < RW; i++)
    begin : g_sqrt
        qrs_sqrt_cell #(.RW(RW)) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (sq_valid[i]),
            .rem_in    (sq_rem[i]),
            .root_in   (sq_root[i]),
            .rad_in    (sq_rad[i]),
            .out_valid (sq_valid[i+1]),
            .rem_out   (sq_rem[i+1]),
            .root_out  (sq_root[i+1]),
            .rad_out   (sq_rad[i+1])
        );

        always_ff @(posedge clk)
        begin
            sq_side_reg[i+1] <= sq_side_reg[i];
        end
    end

    // ---------------- stage 3: numerators, signs, divisor ----------------
    // With D zero the root is zero, so the first numerator is -b as needed.
    qrs_sq_side_t           sq_end;
    logic signed [NUMW-1:0] bs, sv, n1, n2;
    logic [NUMW-1:0]        m1, m2;
    logic signed [COEF_W+1:0] a2;
    logic [COEF_W+1:0]      a2_mag;

    always_comb
    begin
        sq_end = sq_side_reg[RW];
        bs     = NUMW'(sq_end.b) <<< (ROOT_FRAC_BITS - COEF_FRAC);
        sv     = $signed(NUMW'(sq_root[RW]));
        n1     = sv - bs;
        n2     = -(bs + sv);
        m1     = n1[NUMW-1] ? NUMW'(-n1) : NUMW'(n1);
        m2     = n2[NUMW-1] ? NUMW'(-n2) : NUMW'(n2);
        a2     = (COEF_W+2)'(sq_end.a) <<< 1;
        a2_mag = a2[COEF_W+1] ? (COEF_W+2)'(-a2) : (COEF_W+2)'(a2);
    end

    logic            dv_valid [0:QW];
    logic [DENW-1:0] dv_den   [0:QW];
    logic [DENW-1:0] dv_rem1  [0:QW];
    logic [QW-1:0]   dv_num1  [0:QW];
    logic [DENW-1:0] dv_rem2  [0:QW];
    logic [QW-1:0]   dv_num2  [0:QW];
    qrs_div_side_t   dv_side_reg [0:QW];

    logic            s3_valid_reg;
    logic [DENW-1:0] s3_den_reg;
    logic [QW-1:0]   s3_num1_reg, s3_num2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s3_valid_reg <= sq_valid[RW];
        end
    end

    always_ff @(posedge clk)
    begin
        s3_den_reg           <= a2_mag[DENW-1:0];
        s3_num1_reg          <= {m1, {COEF_FRAC{1'b0}}};
        s3_num2_reg          <= {m2, {COEF_FRAC{1'b0}}};
        dv_side_reg[0].count <= sq_end.count;
        dv_side_reg[0].neg1  <= n1[NUMW-1] ^ sq_end.a[COEF_W-1];
        dv_side_reg[0].neg2  <= n2[NUMW-1] ^ sq_end.a[COEF_W-1];
    end

    assign dv_valid[0] = s3_valid_reg;
    assign dv_den[0]   = s3_den_reg;
    assign dv_rem1[0]  = '0;
    assign dv_num1[0]  = s3_num1_reg;
    assign dv_rem2[0]  = '0;
    assign dv_num2[0]  = s3_num2_reg;

    // ---------------- divider chain: one cell per quotient bit, two lanes ----------------
    for (genvar j = 0; j < QW; j++)
    begin : g_div
        qrs_div_cell #(.QW(QW), .DENW(DENW)) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (dv_valid[j]),
            .den_in    (dv_den[j]),
            .rem1_in   (dv_rem1[j]),
            .num1_in   (dv_num1[j]),
            .rem2_in   (dv_rem2[j]),
            .num2_in   (dv_num2[j]),
            .out_valid (dv_valid[j+1]),
            .den_out   (dv_den[j+1]),
            .rem1_out  (dv_rem1[j+1]),
            .num1_out  (dv_num1[j+1]),
            .rem2_out  (dv_rem2[j+1]),
            .num2_out  (dv_num2[j+1])
        );

        always_ff @(posedge clk)
        begin
            dv_side_reg[j+1] <= dv_side_reg[j];
        end
    end

    // ---------------- output stage: sign, saturate, drop absent roots ----------------
    qrs_div_side_t          dv_end;
    logic [SATW-1:0]        q1, q2, lim1, lim2, qs1, qs2;
    logic signed [OUT_BITS-1:0] r1, r2;
    qrs_out_t               result_reg, result_next;
    logic                   done_reg;

    always_comb
    begin
        dv_end = dv_side_reg[QW];
        q1     = SATW'(dv_num1[QW]);
        q2     = SATW'(dv_num2[QW]);
        lim1   = dv_end.neg1 ? (SATW'(1) << (OUT_BITS - 1))
                             : ((SATW'(1) << (OUT_BITS - 1)) - SATW'(1));
        lim2   = dv_end.neg2 ? (SATW'(1) << (OUT_BITS - 1))
                             : ((SATW'(1) << (OUT_BITS - 1)) - SATW'(1));
        qs1    = (q1 > lim1) ? lim1 : q1;
        qs2    = (q2 > lim2) ? lim2 : q2;
        r1     = dv_end.neg1 ? -$signed(qs1[OUT_BITS-1:0]) : $signed(qs1[OUT_BITS-1:0]);
        r2     = dv_end.neg2 ? -$signed(qs2[OUT_BITS-1:0]) : $signed(qs2[OUT_BITS-1:0]);

        result_next.root_count  = dv_end.count;
        result_next.root_first  = '0;
        result_next.root_second = '0;
        case (dv_end.count)
            CNT_DOUBLE:
            begin
                result_next.root_first = r1;
            end
            CNT_TWO:
            begin
                result_next.root_first  = r1;
                result_next.root_second = r2;
            end
            default:
            begin
                result_next.root_first = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= dv_valid[QW];
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

    `ASSERT_IMPL(a_fixed_latency, clk, rst_n, start && !busy, ##LAT done)
    `ASSERT_IMPL(a_second_only_for_two, clk, rst_n,
                 done && result.root_count != CNT_TWO, result.root_second == '0)
    `ASSERT_IMPL(a_no_first_without_root, clk, rst_n,
                 done && (result.root_count == CNT_NONE || result.root_count == CNT_AZERO),
                 result.root_first == '0)
endmodule

// File: dv/quadratic_root_solver_tb.sv
`timescale 1ns / 1ps

module quadratic_root_solver_tb;

    import qrs_pkg::*;

    localparam int RAND_EQUATIONS = 1900;
    // Pipeline depth at default parameters, with margin for the drain
    localparam int DRAIN_CYCLES   = 80;
    localparam int DRAIN_LIMIT    = 5000;

    logic     clk;
    logic     rst_n;
    logic     start;
    logic     busy;
    qrs_in_t  coef;
    logic     done;
    qrs_out_t result;

    // Roots still in flight, oldest first
    qrs_out_t pending_roots[$];
    int       mismatches;

    // One directed transaction: coefficients plus an optional hand-computed answer
    typedef struct {
        logic signed [15:0] a;
        logic signed [15:0] b;
        logic signed [15:0] c;
        bit                 known;
        logic [1:0]         count;
        logic signed [39:0] first;
        logic signed [39:0] second;
    } eq_row_t;

    eq_row_t directed_rows[$];

    quadratic_root_solver dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .coef   (coef),
        .done   (done),
        .result (result)
    );

    always #5 clk = ~clk;

    // Floor square root of a 64-bit value, one result bit per step
    function automatic logic [63:0] floor_sqrt(input logic [63:0] x);
        logic [63:0] root;
        logic [63:0] trial;
        root = 0;
        for (int i = 31; i >= 0; i--)
        begin
            trial = root | (64'd1 << i);
            if (trial * trial <= x)
                root = trial;
        end
        return root;
    endfunction

    // Quotient of a Q.16 numerator by a Q.8 denominator, truncated and clamped to 40 bits
    function automatic logic [39:0] scaled_quotient(input longint num, input longint den);
        bit          neg;
        logic [63:0] nm;
        logic [63:0] dm;
        logic [63:0] q;
        neg = (num < 0) != (den < 0);
        nm  = (num < 0) ? -num : num;
        dm  = (den < 0) ? -den : den;
        nm  = nm << COEF_FRAC;
        q   = (dm != 0) ? nm / dm : 0;
        if (neg)
        begin
            if (q > (64'd1 << 39))
                q = 64'd1 << 39;
            q = -q;
        end
        else if (q > (64'd1 << 39) - 1)
            q = (64'd1 << 39) - 1;
        return q[39:0];
    endfunction

    function automatic qrs_out_t solve_roots(input qrs_in_t eq);
        qrs_out_t    r;
        longint      a;
        longint      b;
        longint      c;
        longint      disc;
        longint      bs;
        longint      s;
        a = eq.coef_a;
        b = eq.coef_b;
        c = eq.coef_c;
        r = '0;
        if (a == 0)
        begin
            r.root_count = CNT_AZERO;
            return r;
        end
        // Exact at 16-bit coefficients
        disc = b * b - 4 * a * c;
        if (disc < 0)
        begin
            r.root_count = CNT_NONE;
            return r;
        end
        bs = b * (64'sd1 << (ROOT_FRAC_DEF - COEF_FRAC));
        if (disc == 0)
        begin
            r.root_count = CNT_DOUBLE;
            r.root_first = scaled_quotient(-bs, 2 * a);
            return r;
        end
        s = floor_sqrt(disc << (2 * ROOT_FRAC_DEF - 2 * COEF_FRAC));
        r.root_count  = CNT_TWO;
        r.root_first  = scaled_quotient(-bs + s, 2 * a);
        r.root_second = scaled_quotient(-(bs + s), 2 * a);
        return r;
    endfunction

    function automatic logic signed [15:0] rand_coef();
        case ($urandom_range(0, 9)) inside
            0: return ($urandom_range(0, 1) != 0) ? 16'sh7fff : 16'sh8000;
            [1:3]: return $signed(16'($urandom_range(0, 2047))) - 16'sd1024;
            default: return 16'($urandom);
        endcase
    endfunction

    // Hold one transaction on the inputs until it is accepted
    task automatic send_equation(input qrs_in_t eq, input bit known, input qrs_out_t answer);
        start <= 1'b1;
        coef  <= eq;
        forever
        begin
            @(posedge clk);
            if (!busy)
                break;
            @(negedge clk);
        end
        pending_roots.push_back(known ? answer : solve_roots(eq));
        @(negedge clk);
    endtask

    // Drop start for a random gap; zero length keeps the burst going
    task automatic idle_gap(input int cycles);
        if (cycles > 0)
        begin
            start <= 1'b0;
            coef  <= 16'($urandom) == 0 ? '0 : 48'({$urandom, $urandom});
            repeat (cycles) @(negedge clk);
        end
    endtask

    task automatic add_row(input int a, input int b, input int c, input bit known,
                           input logic [1:0] cnt, input longint f, input longint s);
        eq_row_t row;
        row.a = 16'(a);
        row.b = 16'(b);
        row.c = 16'(c);
        row.known = known;
        row.count = cnt;
        row.first = 40'(f);
        row.second = 40'(s);
        directed_rows.push_back(row);
    endtask

    // Compare every result against the oldest pending expectation
    always @(posedge clk)
    begin
        qrs_out_t exp_roots;
        if (rst_n && done)
        begin
            if (pending_roots.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: count=%0d first=%0d second=%0d",
                             result.root_count, result.root_first, result.root_second);
            end
            else
            begin
                exp_roots = pending_roots.pop_front();
                if (result.root_count !== exp_roots.root_count ||
                    result.root_first !== exp_roots.root_first ||
                    result.root_second !== exp_roots.root_second)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp count=%0d first=%0d second=%0d, got %0d %0d %0d",
                                 exp_roots.root_count, exp_roots.root_first,
                                 exp_roots.root_second, result.root_count,
                                 result.root_first, result.root_second);
                end
            end
        end
    end

    initial
    begin
        #2_000_000;
        $display("** quadratic_root_solver: FAILED **");
        $finish;
    end

    initial
    begin
        qrs_in_t eq;
        qrs_out_t none;
        int burst;
        int sent;
        int t;
        int drain;
        bit passed;

        clk = 1'b0;
        rst_n = 1'b0;
        start = 1'b0;
        coef = '0;
        mismatches = 0;
        none = '0;

        // Zero a is flagged with no roots
        add_row(0, 0, 0, 1, CNT_AZERO, 0, 0);
        add_row(0, 32767, -32768, 1, CNT_AZERO, 0, 0);
        add_row(0, -32768, 32767, 1, CNT_AZERO, 0, 0);
        // Negative discriminant: x^2 + 1
        add_row(256, 0, 256, 1, CNT_NONE, 0, 0);
        add_row(-32768, 0, -32768, 1, CNT_NONE, 0, 0);
        // Double roots: x^2 + 2x + 1 gives -1.0, and the trivial zero root
        add_row(256, 512, 256, 1, CNT_DOUBLE, -65536, 0);
        add_row(1, 0, 0, 1, CNT_DOUBLE, 0, 0);
        // Checked against solve_roots: x^2 - 1 with two roots, and the coefficient extremes
        add_row(256, 0, -256, 0, 0, 0, 0);
        add_row(32767, 32767, 32767, 0, 0, 0, 0);
        add_row(-32768, -32768, -32768, 0, 0, 0, 0);
        add_row(32767, -32768, -32768, 0, 0, 0, 0);
        add_row(-32768, 32767, 32767, 0, 0, 0, 0);
        add_row(1, -32768, 1, 0, 0, 0, 0);
        add_row(-1, 32767, 32767, 0, 0, 0, 0);
        add_row(1, 32767, -32768, 0, 0, 0, 0);
        add_row(-1, -1, -1, 0, 0, 0, 0);
        add_row(-1, 0, 1, 0, 0, 0, 0);
        add_row(3, 7, 2, 0, 0, 0, 0);

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
        begin
            eq.coef_a = directed_rows[i].a;
            eq.coef_b = directed_rows[i].b;
            eq.coef_c = directed_rows[i].c;
            send_equation(eq, directed_rows[i].known,
                          '{directed_rows[i].count, directed_rows[i].first,
                            directed_rows[i].second});
            if (i % 5 == 4)
                idle_gap($urandom_range(1, 4));
        end

        // Random bursts; some long stretches run gapless
        sent = 0;
        while (sent < RAND_EQUATIONS)
        begin
            burst = $urandom_range(1, 40);
            for (int k = 0; k < burst; k++)
            begin
                case ($urandom_range(0, 9))
                    0:
                    begin
                        // Perfect square: b = 2at, c = at^2 forces a zero discriminant
                        t = $urandom_range(0, 20) - 10;
                        eq.coef_a = 16'($signed(16'($urandom_range(1, 150))) *
                                        (($urandom_range(0, 1) != 0) ? 1 : -1));
                        eq.coef_b = 16'(2 * eq.coef_a * t);
                        eq.coef_c = 16'(eq.coef_a * t * t);
                    end
                    1:
                    begin
                        eq.coef_a = 0;
                        eq.coef_b = rand_coef();
                        eq.coef_c = rand_coef();
                    end
                    default:
                    begin
                        eq.coef_a = rand_coef();
                        eq.coef_b = rand_coef();
                        eq.coef_c = rand_coef();
                    end
                endcase
                send_equation(eq, 0, none);
                sent++;
            end
            idle_gap(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12));
        end
        start <= 1'b0;

        // Drain the pipe, then let any stray result surface
        drain = 0;
        while (pending_roots.size() != 0 && drain < DRAIN_LIMIT)
        begin
            @(posedge clk);
            drain++;
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        passed = (mismatches == 0) && (pending_roots.size() == 0);
        if (passed)
            $display("** quadratic_root_solver: PASSED **");
        else
            $display("** quadratic_root_solver: FAILED **");
        $finish;
    end

endmodule

// File: sim.f
+incdir+sv
sv/qrs_pkg.sv
sv/qrs_sqrt_cell.sv
sv/qrs_div_cell.sv
sv/quadratic_root_solver.sv
dv/quadratic_root_solver_tb.sv
